@@ rtl/lpr_pkg.sv @@
// shared types and codes for the linear parameter ramp
`timescale 1ns / 1ps

package lpr_pkg;

   // request kinds carried on req_tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // fixed field widths of the stream payloads
   localparam int VALUE_W     = 32;
   localparam int RAMP_FIELD_W = 24;

   // status of the serial divider as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/linear_parameter_ramp.sv @@
// linear ramp smoother: sequencer, level registers and output register
// tick request: gap, magnitude, move and output steps of the sequencer in order,
//    the output step waiting for a free output register; one request at a time
// set request with non-zero ramp: gap, magnitude, divide and fix steps in order,
//    the serial divider producing one quotient bit per cycle
// set request with zero ramp: back to ready in the cycle after acceptance
// reset (synchronous, active high) clears levels, step, running and handshakes
`timescale 1ns / 1ps

module linear_parameter_ramp
   import lpr_pkg::*;
#(
   parameter int FRAC_BITS = 32,
   parameter int RAMP_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic        csr_wdata,     // running
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,     // target_value [31:0], ramp_samples [55:32]
   input  logic        req_tuser,     // operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // current_value [31:0]
   output logic        rsp_tuser      // at_target
);

   localparam int WIDE  = FRAC_BITS + 16;
   localparam int GW    = WIDE + 1;
   localparam int SHIFT = FRAC_BITS - 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_MAG,
      ST_DIV,
      ST_FIX,
      ST_MOVE,
      ST_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic                       running_ff;
   logic                       op_ff, op_in;
   logic signed [VALUE_W-1:0]  target_level_ff, target_level_in;
   logic signed [WIDE-1:0]     present_ff, present_in;
   logic signed [GW-1:0]       step_ff, step_in;
   logic [GW-1:0]              step_mag_ff, step_mag_in;
   logic signed [GW-1:0]       gap_ff, gap_in;
   logic [GW-1:0]              mag_ff, mag_in;
   logic [RAMP_BITS-1:0]       ramp_ff, ramp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                       rsp_at_ff, rsp_at_in;

   logic signed [VALUE_W-1:0]  req_target;
   logic [RAMP_BITS+RAMP_FIELD_W-1:0] ramp_cat;
   logic [RAMP_BITS-1:0]       req_ramp;
   logic signed [WIDE-1:0]     tw;
   logic signed [WIDE-1:0]     tw_req;
   logic                       req_fire;
   logic                       div_start;
   logic [GW-1:0]              div_quotient;
   div_status_type             div_status;

   // request fields, ramp length trimmed or zero-extended to the configured width
   assign req_target = req_tdata[VALUE_W-1:0];
   assign ramp_cat   = {{RAMP_BITS{1'b0}}, req_tdata[VALUE_W+RAMP_FIELD_W-1:VALUE_W]};
   assign req_ramp   = ramp_cat[RAMP_BITS-1:0];
   assign req_fire   = req_tvalid && req_tready;

   // targets widened to the level format
   assign tw     = WIDE'(target_level_ff) <<< SHIFT;
   assign tw_req = WIDE'(req_target) <<< SHIFT;

   assign div_start = (state_ff == ST_MAG) && (op_ff == OP_SET);

   lpr_divider #(
      .DW (GW),
      .VW (RAMP_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_in),
      .divisor  (ramp_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // sequencer next state and datapath
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      target_level_in = target_level_ff;
      present_in      = present_ff;
      step_in         = step_ff;
      step_mag_in     = step_mag_ff;
      gap_in          = gap_ff;
      mag_in          = gap_ff[GW-1] ? GW'(-gap_ff) : GW'(gap_ff);
      ramp_in         = ramp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_value_in    = rsp_value_ff;
      rsp_at_in       = rsp_at_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in = req_tuser;
               if (req_tuser == OP_SET) begin
                  target_level_in = req_target;
                  ramp_in         = req_ramp;
                  if (!running_ff || (req_ramp == '0)) begin
                     present_in = tw_req;
                  end
                  if (req_ramp == '0) begin
                     step_in     = '0;
                     step_mag_in = '0;
                     state_in    = ST_IDLE;
                  end else begin
                     state_in = ST_GAP;
                  end
               end else begin
                  state_in = ST_GAP;
               end
            end
         end
         // remaining distance to the target
         ST_GAP: begin
            gap_in   = GW'(tw) - GW'(present_ff);
            state_in = ST_MAG;
         end
         // distance magnitude, divider launched for a set
         ST_MAG: begin
            state_in = (op_ff == OP_SET) ? ST_DIV : ST_MOVE;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_FIX;
            end
         end
         // quotient takes the sign of the distance
         ST_FIX: begin
            step_mag_in = div_quotient;
            step_in     = gap_ff[GW-1] ? -$signed(div_quotient) : $signed(div_quotient);
            state_in    = ST_IDLE;
         end
         // one step, or snap to the target once the gap is under a step or the step is zero
         ST_MOVE: begin
            if ((step_mag_ff != '0) && (mag_ff >= step_mag_ff)) begin
               present_in = present_ff + step_ff[WIDE-1:0];
            end else begin
               present_in = tw;
            end
            state_in = ST_OUT;
         end
         // hand the level over once the output register is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = present_ff[WIDE-1:SHIFT];
               rsp_at_in    = (present_ff == tw);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         running_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         target_level_ff <= '0;
         present_ff      <= '0;
         step_ff         <= '0;
         step_mag_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         target_level_ff <= target_level_in;
         present_ff      <= present_in;
         step_ff         <= step_in;
         step_mag_ff     <= step_mag_in;
         if (csr_we) begin
            running_ff <= csr_wdata;
         end
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      gap_ff       <= gap_in;
      mag_ff       <= mag_in;
      ramp_ff      <= ramp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_at_ff    <= rsp_at_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_at_ff;

   // divider only launched when free, and only finishes while awaited
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider launched while busy");

   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");

   // no new request while the divider is working
   assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_tready)
      else $error("ready while dividing");

   // step and its magnitude agree on zero
   assert property (@(posedge clock) disable iff (reset)
      (step_mag_ff == '0) == (step_ff == '0))
      else $error("step magnitude out of step with step");

endmodule

@@ rtl/lpr_divider.sv @@
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lpr_divider
   import lpr_pkg::*;
#(
   parameter int DW = 49,
   parameter int VW = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DW-1:0]        dividend,
   input  logic [VW-1:0]        divisor,
   output logic [DW-1:0]        quotient,
   output div_status_type       status
);

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [CW-1:0] count_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(DW);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[VW-1:0] : shifted[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
